// ===== design/okvt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvt_pkg
// Shared sizes, codes and types of the ordered key/value table.
// ----------------------------------------------------------------------------
package okvt_pkg;

   localparam int CAPACITY    = 256;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;

   localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

   // entries are reduced in groups, all groups in one registered level
   localparam int GROUP_SIZE = 16;
   localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int LANES      = NUM_GROUPS * GROUP_SIZE;

   // transfer field widths
   localparam int OP_WIDTH       = 3;
   localparam int KEY_FIELD      = 32;
   localparam int VALUE_FIELD    = 32;
   localparam int POS_WIDTH      = 8;
   localparam int STATUS_WIDTH   = 2;
   localparam int ENTRY_CNT_W    = 9;
   localparam int REQ_DATA_WIDTH = 80;
   localparam int RSP_DATA_WIDTH = 80;

   localparam logic [OP_WIDTH-1:0] OP_SET    = 3'd0;
   localparam logic [OP_WIDTH-1:0] OP_GET    = 3'd1;
   localparam logic [OP_WIDTH-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_WIDTH-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_WIDTH-1:0] OP_READ   = 3'd4;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_MISSING = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL    = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RANGE   = 2'd3;

   typedef logic [KEY_WIDTH-1:0]   key_type;
   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   // broadcast lookup, sampled by every cell on strobe
   typedef struct packed {
      logic    strobe;
      logic    lookup;
      key_type key;
   } probe_type;

   // per-cell write controls
   typedef struct packed {
      logic shift;
      logic load_new;
      logic update;
   } cell_ctl_type;

   // broadcast write data
   typedef struct packed {
      key_type   key;
      value_type value;
   } entry_type;

endpackage

// ===== design/okvt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvt_cell
// One table entry: holds a key/value pair, compares against the broadcast
// key, and loads from its upper neighbor when a delete closes the gap.
// ----------------------------------------------------------------------------
module okvt_cell (
   input  logic                  clock,
   input  okvt_pkg::probe_type    probe,
   input  logic                  in_range,
   input  logic                  rd_sel,
   input  okvt_pkg::cell_ctl_type ctl,
   input  okvt_pkg::entry_type    wr,
   input  okvt_pkg::entry_type    next_entry,
   output okvt_pkg::entry_type    entry,
   output logic                  match,
   output okvt_pkg::entry_type    pick
);
   import okvt_pkg::*;

   key_type   key_ff,   key_in;
   value_type value_ff, value_in;
   logic      match_ff, match_in;
   logic      sel_ff,   sel_in;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      if (ctl.shift) begin
         key_in   = next_entry.key;
         value_in = next_entry.value;
      end else if (ctl.load_new) begin
         key_in   = wr.key;
         value_in = wr.value;
      end else if (ctl.update) begin
         value_in = wr.value;
      end
      match_in = match_ff;
      sel_in   = sel_ff;
      if (probe.strobe) begin
         match_in = probe.lookup && in_range && (key_ff == probe.key);
         sel_in   = rd_sel;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      match_ff <= match_in;
      sel_ff   <= sel_in;
   end

   assign entry.key   = key_ff;
   assign entry.value = value_ff;
   assign match       = match_ff;
   assign pick.key    = sel_ff ? key_ff : '0;
   assign pick.value  = (match_ff || sel_ff) ? value_ff : '0;

endmodule

// ===== design/okvt_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// okvt_reduce
// First level of the match reduction: per-group hit flags, picked entries
// and in-group match prefixes, all registered.
// ----------------------------------------------------------------------------
module okvt_reduce (
   input  logic                 clock,
   input  logic                 lane_match [okvt_pkg::LANES],
   input  okvt_pkg::entry_type   lane_pick  [okvt_pkg::LANES],
   output logic [okvt_pkg::NUM_GROUPS-1:0] group_any,
   output okvt_pkg::entry_type   group_pick [okvt_pkg::NUM_GROUPS],
   output logic [okvt_pkg::LANES-1:0]      lane_prefix
);
   import okvt_pkg::*;

   logic [NUM_GROUPS-1:0] group_any_ff,  group_any_in;
   entry_type             group_pick_ff [NUM_GROUPS];
   entry_type             group_pick_in [NUM_GROUPS];
   logic [LANES-1:0]      lane_prefix_ff, lane_prefix_in;

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_any_in[g]        = 1'b0;
         group_pick_in[g].key   = '0;
         group_pick_in[g].value = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            group_any_in[g]        = group_any_in[g] | lane_match[g * GROUP_SIZE + k];
            group_pick_in[g].key   = group_pick_in[g].key
                                     | lane_pick[g * GROUP_SIZE + k].key;
            group_pick_in[g].value = group_pick_in[g].value
                                     | lane_pick[g * GROUP_SIZE + k].value;
         end
      end
      // inclusive prefix: a match at or below this lane within its group
      for (int l = 0; l < LANES; l++) begin
         lane_prefix_in[l] = 1'b0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (k <= (l % GROUP_SIZE)) begin
               lane_prefix_in[l] = lane_prefix_in[l]
                                   | lane_match[(l / GROUP_SIZE) * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      group_any_ff   <= group_any_in;
      group_pick_ff  <= group_pick_in;
      lane_prefix_ff <= lane_prefix_in;
   end

   assign group_any   = group_any_ff;
   assign group_pick  = group_pick_ff;
   assign lane_prefix = lane_prefix_ff;

endmodule

// ===== design/ordered_key_value_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_key_value_table
// Insertion-ordered key/value table in a row of entry cells: set, get,
// delete with gap closing, clear, and read at position.
// ----------------------------------------------------------------------------
//  channel   direction  role
//  req_*     in         operation: op, key, value_in, position
//  rsp_*     out        result: status, found_value, found_key, entry_count
//
//  An item is handled in order: cells compare in parallel at the accepting
//  edge, the group reduction registers next, and the commit cycle combines
//  the groups and writes the cells (update, append or shift down by one).
//  Reset clears state, count and rsp_tvalid; entry contents need no clearing.
//  A commit waits while the previous result is not yet transferred.
// ----------------------------------------------------------------------------
module ordered_key_value_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[2:0], key[34:3], value_in[66:35], position[74:67], zero fill
   input  logic [okvt_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[1:0], found_value[33:2], found_key[65:34], entry_count[74:66],
   // zero fill
   output logic [okvt_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import okvt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GROUP,
      ST_APPLY
   } state_type;

   state_type               state_ff;
   logic [OP_WIDTH-1:0]     op_ff;
   key_type                 key_ff;
   value_type               value_ff;
   logic [POS_WIDTH-1:0]    pos_ff;
   count_type               count_ff;
   logic                    rsp_valid_ff;
   logic [STATUS_WIDTH-1:0] status_ff;
   logic [VALUE_FIELD-1:0]  found_value_ff;
   logic [KEY_FIELD-1:0]    found_key_ff;
   logic [ENTRY_CNT_W-1:0]  entry_count_ff;

   logic [OP_WIDTH-1:0]  req_op;
   key_type              req_key;
   value_type            req_value;
   logic [POS_WIDTH-1:0] req_pos;
   logic                 accept;

   assign req_op    = req_tdata[2:0];
   assign req_key   = KEY_WIDTH'(req_tdata[34:3]);
   assign req_value = VALUE_WIDTH'(req_tdata[66:35]);
   assign req_pos   = req_tdata[74:67];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept    = req_tvalid && req_tready;

   probe_type    probe;
   entry_type    wr;
   entry_type    cell_entry [CAPACITY];
   entry_type    cell_pick  [CAPACITY];
   logic         cell_match [CAPACITY];
   cell_ctl_type cell_ctl   [CAPACITY];
   logic         lane_match [LANES];
   entry_type    lane_pick  [LANES];

   logic [NUM_GROUPS-1:0] group_any;
   entry_type             group_pick [NUM_GROUPS];
   logic [LANES-1:0]      lane_prefix;
   logic [NUM_GROUPS-1:0] group_before;

   assign probe.strobe = accept;
   assign probe.lookup = (req_op == OP_SET) || (req_op == OP_GET) || (req_op == OP_DELETE);
   assign probe.key    = req_key;
   assign wr.key       = key_ff;
   assign wr.value     = value_ff;

   // commit-cycle decisions
   logic      hit, room, pos_ok, go;
   entry_type found;

   always_comb begin
      hit         = |group_any;
      found.key   = '0;
      found.value = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         found.key   = found.key | group_pick[g].key;
         found.value = found.value | group_pick[g].value;
         group_before[g] = 1'b0;
         for (int h = 0; h < NUM_GROUPS; h++) begin
            if (h < g) begin
               group_before[g] = group_before[g] | group_any[h];
            end
         end
      end
   end

   assign room   = (count_ff < COUNT_WIDTH'(CAPACITY));
   assign pos_ok = (int'(pos_ff) < int'(count_ff));
   assign go     = (state_ff == ST_APPLY) && (!rsp_valid_ff || rsp_tready);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      entry_type next_entry;
      logic      in_range;
      logic      rd_sel;

      if (i == CAPACITY - 1) begin : g_top
         assign next_entry = '0;
      end else begin : g_mid
         assign next_entry = cell_entry[i + 1];
      end

      assign in_range = (COUNT_WIDTH'(i) < count_ff);
      assign rd_sel   = (req_op == OP_READ) && (int'(req_pos) == i);

      assign cell_ctl[i].update   = go && (op_ff == OP_SET) && hit && cell_match[i];
      assign cell_ctl[i].load_new = go && (op_ff == OP_SET) && !hit && room
                                    && (count_ff == COUNT_WIDTH'(i));
      // the deleted entry and every entry above it take their upper neighbor
      assign cell_ctl[i].shift    = go && (op_ff == OP_DELETE) && hit
                                    && (lane_prefix[i] || group_before[i / GROUP_SIZE]);

      okvt_cell u_cell (
         .clock      (clock),
         .probe      (probe),
         .in_range   (in_range),
         .rd_sel     (rd_sel),
         .ctl        (cell_ctl[i]),
         .wr         (wr),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .match      (cell_match[i]),
         .pick       (cell_pick[i])
      );
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      if (l < CAPACITY) begin : g_used
         assign lane_match[l] = cell_match[l];
         assign lane_pick[l]  = cell_pick[l];
      end else begin : g_pad
         assign lane_match[l] = 1'b0;
         assign lane_pick[l]  = '0;
      end
   end

   okvt_reduce u_reduce (
      .clock       (clock),
      .lane_match  (lane_match),
      .lane_pick   (lane_pick),
      .group_any   (group_any),
      .group_pick  (group_pick),
      .lane_prefix (lane_prefix)
   );

   logic [STATUS_WIDTH-1:0] status_in;
   logic [VALUE_FIELD-1:0]  found_value_in;
   logic [KEY_FIELD-1:0]    found_key_in;
   count_type               count_in;

   always_comb begin
      status_in      = STATUS_OK;
      found_value_in = '0;
      found_key_in   = '0;
      count_in       = count_ff;
      case (op_ff)
         OP_SET: begin
            if (!hit) begin
               if (room) begin
                  count_in = count_ff + COUNT_WIDTH'(1);
               end else begin
                  status_in = STATUS_FULL;
               end
            end
         end
         OP_GET: begin
            if (hit) begin
               found_value_in = VALUE_FIELD'(found.value);
            end else begin
               status_in = STATUS_MISSING;
            end
         end
         OP_DELETE: begin
            if (hit) begin
               count_in = count_ff - COUNT_WIDTH'(1);
            end else begin
               status_in = STATUS_MISSING;
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_READ: begin
            if (pos_ok) begin
               found_value_in = VALUE_FIELD'(found.value);
               found_key_in   = KEY_FIELD'(found.key);
            end else begin
               status_in = STATUS_RANGE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !go) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff    <= req_op;
                  key_ff   <= req_key;
                  value_ff <= req_value;
                  pos_ff   <= req_pos;
                  state_ff <= ST_GROUP;
               end
            end
            ST_GROUP: begin
               state_ff <= ST_APPLY;
            end
            ST_APPLY: begin
               if (go) begin
                  count_ff       <= count_in;
                  status_ff      <= status_in;
                  found_value_ff <= found_value_in;
                  found_key_ff   <= found_key_in;
                  entry_count_ff <= ENTRY_CNT_W'(count_in);
                  rsp_valid_ff   <= 1'b1;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, entry_count_ff, found_key_ff, found_value_ff, status_ff};

endmodule

// ===== test/tb_ordered_key_value_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_key_value_table
// Self-checking bench for the ordered key/value table. A short table of
// directed operations covers the field extremes, every op and the missing
// and range statuses. Random traffic follows, drawn from a pool of distinct
// keys so that lookups and deletes hit, plus a fill of the table to capacity.
// Each result is checked against its listed value or the bench's shadow table.
// ----------------------------------------------------------------------------
module tb_ordered_key_value_table;
   import okvt_pkg::*;

   localparam logic [OP_WIDTH-1:0] OP_FIRST_UNUSED = 3'd5;
   localparam int POOL_SIZE = CAPACITY + 16;
   localparam int REQ_USED  = OP_WIDTH + KEY_FIELD + VALUE_FIELD + POS_WIDTH;

   typedef struct {
      logic [OP_WIDTH-1:0]  op;
      key_type              key;
      value_type            value_in;
      logic [POS_WIDTH-1:0] position;
   } request_type;

   typedef struct {
      logic [STATUS_WIDTH-1:0] status;
      value_type               found_value;
      key_type                 found_key;
      logic [ENTRY_CNT_W-1:0]  entry_count;
   } reply_type;

   typedef struct {
      request_type req;
      bit          typed;
      reply_type   want;
   } directed_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   // shadow copy of the table
   key_type   shadow_keys [CAPACITY];
   value_type shadow_values [CAPACITY];
   int        shadow_count = 0;

   key_type            key_pool [POOL_SIZE];
   reply_type          pending_replies [$];
   directed_row_type   directed_rows [$];
   reply_type          no_reply = '{default: '0};
   int                 mismatch_count = 0;
   int                 stall_left = 0;
   bit                 no_gaps = 1'b0;

   ordered_key_value_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("** ordered_key_value_table: FAILED **");
      $finish;
   end

   function automatic request_type mk_request(logic [OP_WIDTH-1:0] op, key_type key,
                                              value_type value_in,
                                              logic [POS_WIDTH-1:0] position);
      request_type r;
      r.op       = op;
      r.key      = key;
      r.value_in = value_in;
      r.position = position;
      return r;
   endfunction

   function automatic logic [REQ_DATA_WIDTH-1:0] pack_request(request_type r);
      return {{(REQ_DATA_WIDTH - REQ_USED){1'b0}}, r.position, r.value_in, r.key, r.op};
   endfunction

   // one operation on the shadow table, returns the result it should give
   function automatic reply_type apply_to_shadow(request_type r);
      reply_type rep;
      int        hit;
      rep.status      = STATUS_OK;
      rep.found_value = '0;
      rep.found_key   = '0;
      hit = -1;
      for (int i = 0; i < shadow_count; i++) begin
         if (hit < 0 && shadow_keys[i] == r.key) hit = i;
      end
      case (r.op)
         OP_SET: begin
            if (hit >= 0) begin
               shadow_values[hit] = r.value_in;
            end else if (shadow_count < CAPACITY) begin
               shadow_keys[shadow_count]   = r.key;
               shadow_values[shadow_count] = r.value_in;
               shadow_count++;
            end else begin
               rep.status = STATUS_FULL;
            end
         end
         OP_GET: begin
            if (hit >= 0) rep.found_value = shadow_values[hit];
            else rep.status = STATUS_MISSING;
         end
         OP_DELETE: begin
            if (hit >= 0) begin
               for (int j = hit; j + 1 < shadow_count; j++) begin
                  shadow_keys[j]   = shadow_keys[j + 1];
                  shadow_values[j] = shadow_values[j + 1];
               end
               shadow_count--;
            end else begin
               rep.status = STATUS_MISSING;
            end
         end
         OP_CLEAR: shadow_count = 0;
         OP_READ: begin
            if (int'(r.position) < shadow_count) begin
               rep.found_key   = shadow_keys[r.position];
               rep.found_value = shadow_values[r.position];
            end else begin
               rep.status = STATUS_RANGE;
            end
         end
         default: ;
      endcase
      rep.entry_count = ENTRY_CNT_W'(shadow_count);
      return rep;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_gaps || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic add_row(logic [OP_WIDTH-1:0] op, key_type key, value_type value_in,
                          logic [POS_WIDTH-1:0] position, bit typed,
                          logic [STATUS_WIDTH-1:0] status, value_type found_value,
                          key_type found_key, int entry_count);
      directed_row_type row;
      row.req                    = mk_request(op, key, value_in, position);
      row.typed                  = typed;
      row.want.status            = status;
      row.want.found_value       = found_value;
      row.want.found_key         = found_key;
      row.want.entry_count       = ENTRY_CNT_W'(entry_count);
      directed_rows.push_back(row);
   endtask

   // drives one operation, waits for its transfer and books the result
   task automatic send_request(request_type r, bit typed, reply_type want);
      int        gap;
      reply_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= pack_request(r);
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_to_shadow(r);
      pending_replies.push_back(typed ? want : predicted);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_replies.size() != 0);
   endtask

   function automatic request_type random_request(int pool);
      request_type r;
      int          roll;
      int          top;
      roll = $urandom_range(0, 99);
      if (roll < 35) r.op = OP_SET;
      else if (roll < 60) r.op = OP_GET;
      else if (roll < 75) r.op = OP_DELETE;
      else if (roll < 93) r.op = OP_READ;
      else if (roll < 95) r.op = OP_CLEAR;
      else r.op = OP_FIRST_UNUSED + OP_WIDTH'($urandom_range(0, 2));
      if ($urandom_range(0, 99) < 85) r.key = key_pool[$urandom_range(0, pool - 1)];
      else r.key = $urandom();
      r.value_in = $urandom();
      top = (shadow_count > 255) ? 255 : shadow_count;
      if (shadow_count > 0 && $urandom_range(0, 3) != 0)
         r.position = POS_WIDTH'($urandom_range(0, top));
      else
         r.position = POS_WIDTH'($urandom_range(0, 255));
      return r;
   endfunction

   task automatic random_phase(int items);
      int pool;
      pool = 8;
      for (int n = 0; n < items; n++) begin
         if (n % 50 == 0) begin
            if ($urandom_range(0, 9) < 7) pool = $urandom_range(4, 48);
            else pool = POOL_SIZE;
            no_gaps = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 149) == 0) drain_results();
         send_request(random_request(pool), 1'b0, no_reply);
      end
   endtask

   // result checker and receiver stalls
   always @(posedge clock) begin : rsp_side
      reply_type got;
      reply_type want;
      int        roll;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status      = rsp_tdata[1:0];
         got.found_value = rsp_tdata[33:2];
         got.found_key   = rsp_tdata[65:34];
         got.entry_count = rsp_tdata[74:66];
         if (pending_replies.size() == 0) begin
            $error("result transfer with no operation pending");
            mismatch_count++;
         end else begin
            want = pending_replies.pop_front();
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               mismatch_count++;
            end
            if (got.found_value !== want.found_value) begin
               $error("found_value: expected %h, got %h", want.found_value,
                      got.found_value);
               mismatch_count++;
            end
            if (got.found_key !== want.found_key) begin
               $error("found_key: expected %h, got %h", want.found_key, got.found_key);
               mismatch_count++;
            end
            if (got.entry_count !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d", want.entry_count,
                      got.entry_count);
               mismatch_count++;
            end
         end
      end
      roll = $urandom_range(0, 99);
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!no_gaps && roll < 15) begin
         stall_left = (roll < 2) ? $urandom_range(15, 60) : $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin : stimulus
      key_type scramble;
      scramble = $urandom();
      // odd multiplier keeps every pool key distinct
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = scramble ^ (i * 32'h9E3779B1);

      // empty table first, then extremes of key and value
      add_row(OP_GET, 32'd5, '0, 8'd0, 1, STATUS_MISSING, '0, '0, 0);
      add_row(OP_READ, '0, '0, 8'd0, 1, STATUS_RANGE, '0, '0, 0);
      add_row(OP_DELETE, 32'd5, '0, 8'd0, 1, STATUS_MISSING, '0, '0, 0);
      add_row(OP_CLEAR, '0, '0, 8'd0, 1, STATUS_OK, '0, '0, 0);
      add_row(OP_FIRST_UNUSED, '1, '1, 8'hFF, 1, STATUS_OK, '0, '0, 0);
      add_row(OP_FIRST_UNUSED + 3'd1, '1, '1, 8'hFF, 1, STATUS_OK, '0, '0, 0);
      add_row(OP_FIRST_UNUSED + 3'd2, '1, '1, 8'hFF, 1, STATUS_OK, '0, '0, 0);
      add_row(OP_SET, 32'h8000_0000, 32'hFFFF_FFFF, 8'd0, 1, STATUS_OK, '0, '0, 1);
      add_row(OP_SET, 32'h7FFF_FFFF, 32'h0, 8'd0, 1, STATUS_OK, '0, '0, 2);
      add_row(OP_SET, 32'h0, 32'hA5A5_A5A5, 8'd0, 1, STATUS_OK, '0, '0, 3);
      add_row(OP_SET, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 8'd0, 1, STATUS_OK, '0, '0, 4);
      add_row(OP_GET, 32'h8000_0000, '0, 8'd0, 1, STATUS_OK, 32'hFFFF_FFFF, '0, 4);
      // overwrite keeps the count
      add_row(OP_SET, 32'h8000_0000, 32'h1234_5678, 8'd0, 1, STATUS_OK, '0, '0, 4);
      add_row(OP_READ, '0, '0, 8'd0, 1, STATUS_OK, 32'h1234_5678, 32'h8000_0000, 4);
      add_row(OP_READ, '0, '0, 8'd3, 1, STATUS_OK, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 4);
      add_row(OP_READ, '0, '0, 8'd4, 1, STATUS_RANGE, '0, '0, 4);
      add_row(OP_READ, '0, '0, 8'hFF, 1, STATUS_RANGE, '0, '0, 4);
      // delete in the middle closes the gap
      add_row(OP_DELETE, 32'h7FFF_FFFF, '0, 8'd0, 1, STATUS_OK, '0, '0, 3);
      add_row(OP_READ, '0, '0, 8'd1, 1, STATUS_OK, 32'hA5A5_A5A5, 32'h0, 3);
      add_row(OP_GET, 32'h7FFF_FFFF, '0, 8'd0, 1, STATUS_MISSING, '0, '0, 3);
      add_row(OP_FIRST_UNUSED, 32'h0, '1, 8'd1, 1, STATUS_OK, '0, '0, 3);
      add_row(OP_READ, '0, '0, 8'd2, 0, STATUS_OK, '0, '0, 0);
      add_row(OP_CLEAR, '1, '1, 8'hFF, 1, STATUS_OK, '0, '0, 0);
      add_row(OP_GET, 32'h0, '0, 8'd0, 1, STATUS_MISSING, '0, '0, 0);
      add_row(OP_SET, 32'h0000_1234, 32'hDEAD_BEEF, 8'd0, 0, STATUS_OK, '0, '0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      random_phase(500);
      drain_results();

      // fill to capacity, then push against the full table
      no_gaps = 1'b0;
      send_request(mk_request(OP_CLEAR, '0, '0, '0), 1'b0, no_reply);
      for (int i = 0; i < CAPACITY; i++)
         send_request(mk_request(OP_SET, key_pool[i], $urandom(), '0), 1'b0, no_reply);
      for (int i = 0; i < 8; i++)
         send_request(mk_request(OP_SET, key_pool[CAPACITY + i], $urandom(), '0), 1'b0,
                      no_reply);
      for (int i = 0; i < 20; i++) begin
         send_request(mk_request(OP_SET, key_pool[$urandom_range(0, CAPACITY - 1)],
                                 $urandom(), '0), 1'b0, no_reply);
         send_request(mk_request(OP_GET, key_pool[$urandom_range(0, CAPACITY - 1)],
                                 $urandom(), '0), 1'b0, no_reply);
         send_request(mk_request(OP_READ, $urandom(), $urandom(),
                                 POS_WIDTH'($urandom_range(0, 255))), 1'b0, no_reply);
      end
      send_request(mk_request(OP_READ, '0, '0, 8'hFF), 1'b0, no_reply);
      for (int i = 0; i < 10; i++)
         send_request(mk_request(OP_DELETE, key_pool[$urandom_range(0, CAPACITY - 1)],
                                 $urandom(), '0), 1'b0, no_reply);
      for (int i = 8; i < 16; i++)
         send_request(mk_request(OP_SET, key_pool[CAPACITY + i], $urandom(), '0), 1'b0,
                      no_reply);
      drain_results();

      random_phase(650);
      drain_results();
      repeat (10) @(posedge clock);

      if (mismatch_count == 0 && pending_replies.size() == 0) begin
         $display("** ordered_key_value_table: PASSED **");
      end else begin
         $display("** ordered_key_value_table: FAILED **");
      end
      $finish;
   end

endmodule
